@@ hw/rtl/alts_pkg.sv @@
`default_nettype none
package alts_pkg;

    localparam int unsigned SLOTS_DEF = 32;
    localparam int unsigned MAX_RES   = 32;
    localparam int unsigned NW        = 6;    // count of firings, holds MAX_RES
    localparam int unsigned TW        = 64;
    localparam int unsigned PW        = 63;
    localparam int unsigned HW        = 16;
    localparam int unsigned IDW       = 5;

    typedef logic [2:0] t_op;

    localparam t_op OP_CLEAR   = 3'd0;
    localparam t_op OP_SET_REL = 3'd1;
    localparam t_op OP_SET_ABS = 3'd2;
    localparam t_op OP_SET_PER = 3'd3;
    localparam t_op OP_CANCEL  = 3'd4;
    localparam t_op OP_FIRE    = 3'd5;

    // decoded command passed from front to back
    typedef struct packed {
        t_op             op;
        logic [IDW-1:0]  id;
        logic [HW-1:0]   handler;
        logic [TW-1:0]   fire;
        logic [PW-1:0]   period;
        logic [PW-1:0]   now;
    } t_cmd;

    // signed compares on raw 64-bit patterns
    function automatic logic sge(input logic [TW-1:0] a, input logic [TW-1:0] b);
        return $signed(a) >= $signed(b);
    endfunction

    function automatic logic slt(input logic [TW-1:0] a, input logic [TW-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/alts_ram.sv @@
`default_nettype none
module alts_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                        i_wdata,
    input  wire logic                                i_re,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/alts_front.sv @@
`default_nettype none
module alts_front
    import alts_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [215:0]  s_axis_tdata,
    input  wire logic [2:0]    s_axis_tuser,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [PW-1:0] i_cfg_data,
    input  wire logic          i_q_full,
    output logic               o_push,
    output t_cmd               o_cmd
);
    logic [PW-1:0] r_boot;
    logic [TW-1:0] tval;
    logic [PW-1:0] now_v;

    assign o_cfg_ready = 1'b1;

    // boot time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot <= '0;
        end else if (i_cfg_valid) begin
            r_boot <= i_cfg_data;
        end
    end

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;
    assign tval          = s_axis_tdata[84:21];
    assign now_v         = s_axis_tdata[210:148];

    // resolve the fire time per opcode
    always_comb begin
        o_cmd.op      = s_axis_tuser;
        o_cmd.id      = s_axis_tdata[4:0];
        o_cmd.handler = s_axis_tdata[20:5];
        o_cmd.period  = s_axis_tdata[147:85];
        o_cmd.now     = now_v;
        unique case (s_axis_tuser)
            OP_SET_REL: o_cmd.fire = {1'b0, now_v} + tval;
            OP_SET_ABS: o_cmd.fire = tval - {1'b0, r_boot};
            default:    o_cmd.fire = tval;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/alts_queue.sv @@
`default_nettype none
module alts_queue
    import alts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);
    localparam int unsigned DEPTH = 2;
    localparam int unsigned AW    = $clog2(DEPTH);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/alts_back.sv @@
`default_nettype none
module alts_back
    import alts_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [87:0]       m_axis_tdata,
    output logic [0:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned RW = HW + PW + TW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_UPD    = 6'b001000,
        S_FINAL  = 6'b010000,
        S_ACK    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [SLOTS-1:0] r_armed, n_armed, r_live, n_live;
    logic [PW-1:0]    r_now, n_now;
    logic [NW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_addr, n_addr;
    logic             r_rd_v, n_rd_v;
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_found, n_found;
    logic [IW-1:0]    r_best, n_best;
    logic [TW-1:0]    r_best_ft, n_best_ft;
    logic [PW-1:0]    r_best_per, n_best_per;
    logic [HW-1:0]    r_best_h, n_best_h;
    logic [TW-1:0]    r_sum_a, n_sum_a, r_sum_b, n_sum_b;
    logic             r_hold_v, n_hold_v;
    logic [IW-1:0]    r_hold_id, n_hold_id;
    logic [HW-1:0]    r_hold_h, n_hold_h;
    logic [TW-1:0]    r_hold_due, n_hold_due;
    logic             r_hold_pend, n_hold_pend;

    // output register
    logic             r_o_v, r_o_user, r_o_last, r_o_pend;
    logic [IW-1:0]    r_o_id;
    logic [HW-1:0]    r_o_h;
    logic [TW-1:0]    r_o_due;

    logic             out_free;
    logic             e_req, e_user, e_last, e_pend;
    logic [IW-1:0]    e_id;
    logic [HW-1:0]    e_h;
    logic [TW-1:0]    e_due;

    logic             we, re;
    logic [IW-1:0]    waddr, raddr;
    logic [RW-1:0]    wdata, rdata;
    logic [TW-1:0]    rd_ft;
    logic [IW-1:0]    cmd_idx;
    logic             cmd_in_range;
    logic [SLOTS-1:0] cmd_oh, best_oh;
    logic [TW-1:0]    nf;

    assign out_free     = !r_o_v || m_axis_tready;
    assign rd_ft        = rdata[TW-1:0];
    assign cmd_idx      = IW'(i_q_cmd.id);
    assign cmd_in_range = (9'(i_q_cmd.id) < 9'(SLOTS));
    assign cmd_oh       = SLOTS'(1) << cmd_idx;
    assign best_oh      = SLOTS'(1) << r_best;
    assign nf           = sge({1'b0, r_now}, r_sum_a) ? r_sum_b : r_sum_a;

    alts_ram #(.W(RW), .D(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // sequencer: op apply, scan for earliest due, update, emit
    always_comb begin
        n_state = r_state;  n_armed = r_armed;  n_live = r_live;
        n_now = r_now;  n_n = r_n;  n_addr = r_addr;  n_rd_v = 1'b0;
        n_rd_idx = r_rd_idx;  n_found = r_found;  n_best = r_best;
        n_best_ft = r_best_ft;  n_best_per = r_best_per;  n_best_h = r_best_h;
        n_sum_a = r_sum_a;  n_sum_b = r_sum_b;
        n_hold_v = r_hold_v;  n_hold_id = r_hold_id;  n_hold_h = r_hold_h;
        n_hold_due = r_hold_due;  n_hold_pend = r_hold_pend;
        o_q_pop = 1'b0;
        we = 1'b0;  waddr = cmd_idx;
        wdata = {i_q_cmd.handler,
                 (i_q_cmd.op == OP_SET_PER) ? i_q_cmd.period : PW'(0),
                 i_q_cmd.fire};
        re = 1'b0;  raddr = IW'(r_addr);
        e_req = 1'b0;  e_user = 1'b1;  e_last = 1'b0;  e_pend = r_hold_pend;
        e_id = r_hold_id;  e_h = r_hold_h;  e_due = r_hold_due;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_ACK;
                    unique case (i_q_cmd.op) inside
                        OP_CLEAR: begin
                            n_armed = '0;
                            n_live  = '0;
                        end
                        OP_SET_REL, OP_SET_ABS, OP_SET_PER: begin
                            if (cmd_in_range) begin
                                we      = 1'b1;
                                n_armed = r_armed | cmd_oh;
                                n_live  = (i_q_cmd.handler != '0) ? (r_live | cmd_oh)
                                                                  : (r_live & ~cmd_oh);
                            end
                        end
                        OP_CANCEL: begin
                            if (cmd_in_range) begin
                                n_armed = r_armed & ~cmd_oh;
                                n_live  = r_live & ~cmd_oh;
                            end
                        end
                        OP_FIRE: begin
                            n_now    = i_q_cmd.now;
                            n_n      = '0;
                            n_hold_v = 1'b0;
                            n_addr   = '0;
                            n_found  = 1'b0;
                            n_state  = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_addr != CW'(SLOTS)) begin
                    re       = 1'b1;
                    n_addr   = r_addr + 1'b1;
                    n_rd_v   = 1'b1;
                    n_rd_idx = IW'(r_addr);
                end else if (!r_rd_v) begin
                    n_state = S_DECIDE;
                end
                // evaluate the slot read last cycle
                if (r_rd_v && r_live[r_rd_idx] && sge({1'b0, r_now}, rd_ft) &&
                    (!r_found || slt(rd_ft, r_best_ft))) begin
                    n_found    = 1'b1;
                    n_best     = r_rd_idx;
                    n_best_ft  = rd_ft;
                    n_best_per = rdata[TW +: PW];
                    n_best_h   = rdata[TW+PW +: HW];
                end
            end
            S_DECIDE: begin
                n_sum_a = r_best_ft + {1'b0, r_best_per};
                n_sum_b = {1'b0, r_now} + {1'b0, r_best_per};
                if (r_found) begin
                    if (!r_hold_v) begin
                        n_state = S_UPD;
                    end else if (out_free) begin
                        e_req    = 1'b1;
                        n_hold_v = 1'b0;
                        n_state  = S_UPD;
                    end
                end else begin
                    n_state = r_hold_v ? S_FINAL : S_ACK;
                end
            end
            S_UPD: begin
                if (r_best_per != '0) begin
                    we    = 1'b1;
                    waddr = r_best;
                    wdata = {r_best_h, r_best_per, nf};
                end else begin
                    n_armed = r_armed & ~best_oh;
                    n_live  = r_live & ~best_oh;
                end
                n_hold_v    = 1'b1;
                n_hold_id   = r_best;
                n_hold_h    = r_best_h;
                n_hold_due  = r_best_ft;
                n_hold_pend = |n_armed;
                n_n         = r_n + 1'b1;
                n_addr      = '0;
                n_found     = 1'b0;
                n_state     = (n_n == NW'(MAX_RES)) ? S_FINAL : S_SCAN;
            end
            S_FINAL: begin
                if (out_free) begin
                    e_req    = 1'b1;
                    e_last   = 1'b1;
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    e_req   = 1'b1;
                    e_user  = 1'b0;
                    e_last  = 1'b1;
                    e_pend  = |r_armed;
                    e_id    = '0;
                    e_h     = '0;
                    e_due   = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_armed  <= '0;
            r_live   <= '0;
            r_rd_v   <= 1'b0;
            r_hold_v <= 1'b0;
            r_found  <= 1'b0;
            r_n      <= '0;
            r_addr   <= '0;
            r_o_v    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_armed  <= n_armed;
            r_live   <= n_live;
            r_rd_v   <= n_rd_v;
            r_hold_v <= n_hold_v;
            r_found  <= n_found;
            r_n      <= n_n;
            r_addr   <= n_addr;
            if (e_req) begin
                r_o_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_rd_idx    <= n_rd_idx;
        r_best      <= n_best;
        r_best_ft   <= n_best_ft;
        r_best_per  <= n_best_per;
        r_best_h    <= n_best_h;
        r_sum_a     <= n_sum_a;
        r_sum_b     <= n_sum_b;
        r_hold_id   <= n_hold_id;
        r_hold_h    <= n_hold_h;
        r_hold_due  <= n_hold_due;
        r_hold_pend <= n_hold_pend;
        if (e_req) begin
            r_o_user <= e_user;
            r_o_last <= e_last;
            r_o_pend <= e_pend;
            r_o_id   <= e_id;
            r_o_h    <= e_h;
            r_o_due  <= e_due;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tuser  = r_o_user;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {2'b00, r_o_pend, r_o_due, r_o_h, IDW'(r_o_id)};

    // checks
    a_upd_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> r_found)
        else $error("update without a chosen slot");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_RES))
        else $error("firing count past limit");
    a_final_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |-> r_hold_v)
        else $error("final word with nothing held");
    a_live_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_live & ~r_armed) == '0)
        else $error("live slot not armed");
endmodule
`default_nettype wire

@@ hw/rtl/alarm_table_scheduler_core.sv @@
// Alarm table scheduler: a set / cancel / clear word is pushed into the queue, popped by the
// back end in its idle state and answered from its acknowledge state through the registered
// output. A fire scan reads the slot memory once per slot, and a new scan follows each firing.
// One command is in the back end at a time; a two-entry queue lets the front keep accepting.
// Reset (i_rst_n low, synchronous) disarms all slots and zeroes the boot offset; slot memory
// contents are left as they were and rewritten on arming.
`default_nettype none
module alarm_table_scheduler_core
    import alts_pkg::*;
#(
    parameter int unsigned ALARM_SLOTS = SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // alarm_id, handler_token, time_value, period, now
    input  wire logic [215:0]  s_axis_tdata,
    // opcode
    input  wire logic [2:0]    s_axis_tuser,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [PW-1:0] i_cfg_data,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // fired_alarm, fired_handler, due_time, pending_any
    output logic [87:0]        m_axis_tdata,
    // fired_valid
    output logic [0:0]         m_axis_tuser,
    output logic               m_axis_tlast
);
    logic q_full, push, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;

    alts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (f_cmd)
    );

    alts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    alts_back #(.SLOTS(ALARM_SLOTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule
`default_nettype wire

@@ tb/sv/tb_alarm_table_scheduler_core.sv @@
`default_nettype none
module tb_alarm_table_scheduler_core;
    import alts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOT_CNT  = 32;
    localparam int unsigned WDOG_MAX  = 4000;
    localparam int unsigned DRAIN_CYC = 60;
    localparam logic [62:0] P_MAX     = {63{1'b1}};

    // opcodes the block ignores but still acknowledges
    localparam t_op OP_SPARE6 = 3'd6;
    localparam t_op OP_SPARE7 = 3'd7;

    typedef struct {
        t_op         op;
        logic [4:0]  id;
        logic [15:0] handler;
        logic [63:0] tval;
        logic [62:0] period;
        logic [62:0] now;
    } alarm_cmd_t;

    typedef struct {
        logic        fired;
        logic [4:0]  id;
        logic [15:0] handler;
        logic [63:0] due;
        logic        last;
        logic        pending;
    } alarm_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [215:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [62:0] i_cfg_data = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic m_axis_tlast;

    alarm_table_scheduler_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // shadow alarm table
    bit          tbl_armed [SLOT_CNT];
    logic [63:0] tbl_fire  [SLOT_CNT];
    logic [62:0] tbl_per   [SLOT_CNT];
    logic [15:0] tbl_hnd   [SLOT_CNT];
    logic [62:0] boot_ticks = '0;

    alarm_cmd_t  cmd_q[$];
    alarm_word_t due_q[$];
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    int unsigned err_cnt = 0;
    int unsigned cmd_cnt = 0;
    int unsigned word_cnt = 0;
    int unsigned fire_cnt = 0;
    int unsigned stall_cyc = 0;
    logic [62:0] tnow = '0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        err_cnt++;
        $display("mismatch word %0d %s: got %h want %h", word_cnt, what, got, want);
    endtask

    function automatic bit table_busy();
        foreach (tbl_armed[i]) if (tbl_armed[i]) return 1'b1;
        return 1'b0;
    endfunction

    // work out the result words of one command and update the shadow table
    task automatic predict_alarms(input alarm_cmd_t c);
        alarm_word_t w;
        logic [63:0] now64, nxt;
        int best, n;
        now64 = {1'b0, c.now};
        n = 0;
        case (c.op)
            OP_CLEAR:   foreach (tbl_armed[i]) tbl_armed[i] = 1'b0;
            OP_SET_REL, OP_SET_ABS, OP_SET_PER: begin
                tbl_armed[c.id] = 1'b1;
                tbl_hnd[c.id]   = c.handler;
                tbl_per[c.id]   = (c.op == OP_SET_PER) ? c.period : '0;
                if (c.op == OP_SET_REL) tbl_fire[c.id] = now64 + c.tval;
                else if (c.op == OP_SET_ABS) tbl_fire[c.id] = c.tval - {1'b0, boot_ticks};
                else tbl_fire[c.id] = c.tval;
            end
            OP_CANCEL: begin
                tbl_armed[c.id] = 1'b0;
                tbl_hnd[c.id]   = '0;
            end
            OP_FIRE: begin
                while (n < MAX_RES) begin
                    best = -1;
                    for (int i = 0; i < SLOT_CNT; i++) begin
                        if (tbl_armed[i] && tbl_hnd[i] != 0
                            && $signed(now64) >= $signed(tbl_fire[i])
                            && (best < 0 || $signed(tbl_fire[i]) < $signed(tbl_fire[best])))
                            best = i;
                    end
                    if (best < 0) break;
                    w.fired = 1'b1;
                    w.id = best[4:0];
                    w.handler = tbl_hnd[best];
                    w.due = tbl_fire[best];
                    if (tbl_per[best] != 0) begin
                        nxt = tbl_fire[best] + {1'b0, tbl_per[best]};
                        if ($signed(now64) >= $signed(nxt)) nxt = now64 + {1'b0, tbl_per[best]};
                        tbl_fire[best] = nxt;
                    end else begin
                        tbl_armed[best] = 1'b0;
                    end
                    w.last = 1'b0;
                    w.pending = table_busy();
                    due_q.push_back(w);
                    n++;
                end
                if (n > 0) begin
                    due_q[due_q.size() - 1].last = 1'b1;
                    fire_cnt += n;
                end
            end
            default: ;
        endcase
        if (n == 0) begin
            w = '{1'b0, 5'd0, 16'd0, 64'd0, 1'b1, table_busy()};
            due_q.push_back(w);
        end
    endtask

    // command driver and input-side accept tracking
    always @(posedge i_clk) begin
        alarm_cmd_t c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                c.op      = s_axis_tuser;
                c.id      = s_axis_tdata[4:0];
                c.handler = s_axis_tdata[20:5];
                c.tval    = s_axis_tdata[84:21];
                c.period  = s_axis_tdata[147:85];
                c.now     = s_axis_tdata[210:148];
                predict_alarms(c);
                cmd_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    c = cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= c.op;
                    s_axis_tdata  <= {5'd0, c.now, c.period, c.tval, c.handler, c.id};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        alarm_word_t w;
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_q.size() == 0) begin
                    report("unexpected word", m_axis_tdata[63:0], '0);
                end else begin
                    w = due_q.pop_front();
                    if (m_axis_tuser[0] !== w.fired) report("fired_valid", m_axis_tuser[0], w.fired);
                    if (m_axis_tdata[4:0] !== w.id) report("fired_alarm", m_axis_tdata[4:0], w.id);
                    if (m_axis_tdata[20:5] !== w.handler)
                        report("fired_handler", m_axis_tdata[20:5], w.handler);
                    if (m_axis_tdata[84:21] !== w.due) report("due_time", m_axis_tdata[84:21], w.due);
                    if (m_axis_tlast !== w.last) report("last_result", m_axis_tlast, w.last);
                    if (m_axis_tdata[85] !== w.pending)
                        report("pending_any", m_axis_tdata[85], w.pending);
                end
                word_cnt++;
            end
        end
    end

    // watchdog: cycles with no accepted word on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cyc <= 0;
        else if (stall_cyc >= WDOG_MAX) begin
            $display("watchdog expired, %0d words pending", due_q.size());
            $display("TB_ERROR");
            $finish;
        end else
            stall_cyc <= stall_cyc + 1;
    end

    task automatic push_cmd(input t_op op, input logic [4:0] id, input logic [15:0] h,
                            input logic [63:0] tv, input logic [62:0] per,
                            input logic [62:0] nw);
        alarm_cmd_t c;
        c = '{op, id, h, tv, per, nw};
        cmd_q.push_back(c);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (cmd_q.size() != 0 || s_axis_tvalid || due_q.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_boot(input logic [62:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        boot_ticks = v;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly near-term alarms so fires happen; a few full-range values
    task automatic push_random();
        t_op op;
        int unsigned sel;
        logic [15:0] h;
        logic [63:0] tv;
        logic [62:0] per, nw;
        sel = $urandom_range(0, 99);
        if (sel < 3) op = OP_CLEAR;
        else if (sel < 28) op = OP_SET_REL;
        else if (sel < 38) op = OP_SET_ABS;
        else if (sel < 58) op = OP_SET_PER;
        else if (sel < 68) op = OP_CANCEL;
        else if (sel < 97) op = OP_FIRE;
        else op = (sel == 97) ? OP_SPARE6 : OP_SPARE7;
        tnow += $urandom_range(0, 40);
        nw = ($urandom_range(0, 19) == 0) ? 63'(rand64()) : tnow;
        h = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom());
        if ($urandom_range(0, 9) == 0) tv = rand64();
        else if (op == OP_SET_REL) tv = 64'($urandom_range(0, 120));
        else if (op == OP_SET_ABS) tv = tnow + boot_ticks + $urandom_range(0, 120);
        else tv = tnow + $urandom_range(0, 120) - 20;
        sel = $urandom_range(0, 9);
        per = (sel < 3) ? '0 : (sel < 9) ? 63'($urandom_range(1, 60)) : 63'(rand64());
        push_cmd(op, 5'($urandom()), h, tv, per, nw);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 1: boot time zero, directed cases then random
        send_idle = 36;
        recv_idle = 49;
        write_boot('0);
        push_cmd(OP_FIRE, 5'd0, 16'd0, '0, '0, '0);               // nothing due
        push_cmd(OP_SET_REL, 5'd0, 16'hFFFF, 64'd10, P_MAX, '0);
        push_cmd(OP_SET_REL, 5'd31, 16'h0001, 64'd10, '0, '0);    // tie with slot 0
        push_cmd(OP_SET_ABS, 5'd5, 16'h0000, 64'd5, '0, '0);      // no handler
        push_cmd(OP_SET_PER, 5'd7, 16'hAAAA, 64'd2, 63'd3, '0);
        push_cmd(OP_FIRE, 5'd0, 16'd0, '0, '0, 63'd20);
        push_cmd(OP_CANCEL, 5'd5, 16'hFFFF, '0, '0, '0);
        push_cmd(OP_CANCEL, 5'd31, 16'd0, '0, '0, '0);
        push_cmd(OP_SPARE6, 5'd31, 16'hFFFF, '1, P_MAX, P_MAX);
        push_cmd(OP_SPARE7, 5'd0, 16'd0, '0, '0, '0);
        push_cmd(OP_SET_ABS, 5'd3, 16'h5555, 64'h8000_0000_0000_0000, '0, '0);
        push_cmd(OP_SET_REL, 5'd4, 16'hFFFF, 64'h7FFF_FFFF_FFFF_FFFF, '0, P_MAX);
        // periodic alarm whose next time wraps negative, refiring to the cap
        push_cmd(OP_SET_PER, 5'd9, 16'h1234, 64'h7FFF_FFFF_FFFF_FFF6,
                 63'h4000_0000_0000_0000, '0);
        push_cmd(OP_FIRE, 5'd0, 16'd0, '0, '0, P_MAX);
        push_cmd(OP_CLEAR, 5'd0, 16'd0, '0, '0, '0);
        push_cmd(OP_FIRE, 5'd0, 16'd0, '0, '0, P_MAX);
        for (int i = 0; i < 50; i++) push_random();
        wait_idle();

        // phase 2: boot time at its maximum
        send_idle = 49;
        recv_idle = 36;
        write_boot(P_MAX);
        push_cmd(OP_SET_ABS, 5'd1, 16'h00FF, '0, '0, '0);
        push_cmd(OP_FIRE, 5'd0, 16'd0, '0, '0, '0);
        for (int i = 0; i < 50; i++) push_random();
        wait_idle();

        // phase 3: random boot time, no idling
        send_idle = 0;
        recv_idle = 0;
        write_boot(63'($urandom_range(0, 1000)));
        for (int i = 0; i < 50; i++) push_random();
        wait_idle();

        if (due_q.size() != 0) report("words never seen", due_q.size(), 0);
        $display("ran %0d commands, checked %0d result words, %0d of them alarm firings",
                 cmd_cnt, word_cnt, fire_cnt);
        $display("covered all opcodes, three boot times, handshake gaps on both sides");
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/alts_pkg.sv
hw/rtl/alts_ram.sv
hw/rtl/alts_front.sv
hw/rtl/alts_queue.sv
hw/rtl/alts_back.sv
hw/rtl/alarm_table_scheduler_core.sv
tb/sv/tb_alarm_table_scheduler_core.sv
